// ===== design/qcrm_pkg.sv =====
// Shared constants, opcodes and types of the QSPI controller register model.
`timescale 1ns / 1ps

package qcrm_pkg;

    localparam int NUM_WORDS_DEF = 64;
    localparam int IDX_W         = 14;
    localparam int DATA_W        = 32;

    localparam logic [IDX_W-1:0] W_CONFIG       = 14'd0;
    localparam logic [IDX_W-1:0] W_SRAM_LEVEL   = 14'd11;
    localparam logic [IDX_W-1:0] W_IRQ_STATUS   = 14'd16;
    localparam logic [IDX_W-1:0] W_IRQ_MASK     = 14'd17;
    localparam logic [IDX_W-1:0] W_IND_RD       = 14'd24;
    localparam logic [IDX_W-1:0] W_IND_RD_BYTES = 14'd27;
    localparam logic [IDX_W-1:0] W_IND_WR       = 14'd28;
    localparam logic [IDX_W-1:0] W_CMD_CTRL     = 14'd36;
    localparam logic [IDX_W-1:0] W_CMD_RD_LO    = 14'd40;
    localparam logic [IDX_W-1:0] W_CMD_RD_HI    = 14'd41;
    localparam logic [IDX_W-1:0] W_CMD_WR_LO    = 14'd42;

    localparam logic [7:0] OP_READ_ID   = 8'h9F;
    localparam logic [7:0] OP_RD_STATUS = 8'h05;
    localparam logic [7:0] OP_RD_CONFIG = 8'h35;
    localparam logic [7:0] OP_WREN      = 8'h06;
    localparam logic [7:0] OP_WRDI      = 8'h04;
    localparam logic [7:0] OP_WRSR      = 8'h01;

    localparam int          BUF_W    = 24;
    localparam logic [23:0] ID_BYTES = 24'h1740C8;
    localparam logic [7:0]  WEL_MASK = 8'h02;

    localparam logic [DATA_W-1:0] IDLE_BIT      = 32'h8000_0000;
    localparam logic [DATA_W-1:0] LEVEL_RD_MASK = 32'h0000_ffff;
    localparam logic [8:0]        CHUNK_BYTES   = 9'd256;

    typedef struct packed {
        logic        go;
        logic [7:0]  op;
        logic        wr_en;
        logic        wr_cnt_nz;
        logic [15:0] wr_data;
    } t_cmd_req;

endpackage

// ===== design/qcrm_cmd.sv =====
// Flash command engine: emulated status and config bytes and the command read buffer.
`timescale 1ns / 1ps

module qcrm_cmd (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  qcrm_pkg::t_cmd_req       i_req,
    output logic [qcrm_pkg::BUF_W-1:0] o_rd_buf
);
    import qcrm_pkg::*;

    logic [7:0]       r_status;
    logic [7:0]       r_cfg_byte;
    logic [BUF_W-1:0] r_buf;
    logic [7:0]       n_status;
    logic [7:0]       n_cfg_byte;
    logic [BUF_W-1:0] n_buf;

    always_comb begin
        n_status   = r_status;
        n_cfg_byte = r_cfg_byte;
        n_buf      = r_buf;
        if (i_req.go) begin
            n_buf = '0;
            unique case (i_req.op)
                OP_READ_ID:   n_buf = ID_BYTES;
                OP_RD_STATUS: n_buf = {16'h0000, r_status};
                OP_RD_CONFIG: n_buf = {16'h0000, r_cfg_byte};
                OP_WREN:      n_status = r_status | WEL_MASK;
                OP_WRDI:      n_status = r_status & ~WEL_MASK;
                OP_WRSR: begin
                    if (i_req.wr_en && ((r_status & WEL_MASK) != 8'h00)) begin
                        n_status = i_req.wr_data[7:0];
                        if (i_req.wr_cnt_nz) begin
                            n_cfg_byte = i_req.wr_data[15:8];
                        end
                    end
                    n_status = n_status & ~WEL_MASK;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= '0;
            r_cfg_byte <= '0;
            r_buf      <= '0;
        end else begin
            r_status   <= n_status;
            r_cfg_byte <= n_cfg_byte;
            r_buf      <= n_buf;
        end
    end

    assign o_rd_buf = r_buf;

endmodule

// ===== design/qspi_controller_register_model.sv =====
// Top level: register file, indirect transfer bookkeeping and interrupt logic.
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+-------------------------------------
//   in       | i_in_valid   | o_in_ready   | i_kind, i_reg_index, i_write_data
//   out      | o_out_valid  | i_out_ready  | o_read_data, o_irq_level
//
// One beat per cycle sustained while the output is not stalled; each beat's result is
// held in the register file read stage and then in the output register.
// After reset a sweep zeroes every word of the register file memory; no beat is taken
// during it.
// A stalled output holds the beat in the output register while one more beat waits in the
// read stage; the input stalls only when both are full.
`timescale 1ns / 1ps

module qspi_controller_register_model #(
    parameter int NUM_WORDS = qcrm_pkg::NUM_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [qcrm_pkg::IDX_W-1:0]  i_reg_index,
    input  logic [qcrm_pkg::DATA_W-1:0] i_write_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [qcrm_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_irq_level
);
    import qcrm_pkg::*;

    localparam int AW = $clog2(NUM_WORDS);

    logic [DATA_W-1:0] r_mem [NUM_WORDS];
    logic [DATA_W-1:0] r_mem_rdata;
    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;

    logic [DATA_W-1:0] r_irq_status, n_irq_status;
    logic [DATA_W-1:0] r_irq_mask,   n_irq_mask;
    logic [DATA_W-1:0] r_ind_rd,     n_ind_rd;
    logic [DATA_W-1:0] r_rd_bytes,   n_rd_bytes;
    logic [DATA_W-1:0] r_ind_wr,     n_ind_wr;
    logic [DATA_W-1:0] r_cmd_ctrl,   n_cmd_ctrl;
    logic [DATA_W-1:0] r_cmd_wr_lo,  n_cmd_wr_lo;
    logic [DATA_W-1:0] r_rd_total,   n_rd_total;
    logic              r_rd_drained, n_rd_drained;

    logic              r_s1_valid;
    logic              r_s1_use_mem;
    logic              r_s1_cfg;
    logic              r_s1_lvl;
    logic [DATA_W-1:0] r_s1_data;
    logic              r_s1_irq;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_irq;

    logic              s1_adv;
    logic              in_acc;
    logic              in_range;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     addr;
    logic              rd_pending;
    logic              lvl_active;
    logic [8:0]        chunk;
    logic [9:0]        lvl_sum;
    logic [DATA_W-1:0] level_word;
    logic [DATA_W-1:0] ind_rd_view;
    logic [DATA_W-1:0] ind_wr_view;
    logic [BUF_W-1:0]  cmd_buf;
    t_cmd_req          cmd_req;
    logic [DATA_W-1:0] rd_special;
    logic              use_mem;
    logic              sel_cfg;
    logic              sel_lvl;
    logic              n_irq_level;
    logic [DATA_W-1:0] s1_result;

    qcrm_cmd u_cmd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (cmd_req),
        .o_rd_buf (cmd_buf)
    );

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_range   = i_reg_index < IDX_W'(NUM_WORDS);
    assign addr       = i_reg_index[AW-1:0];
    assign mem_we     = in_acc && in_range && i_kind;
    assign mem_re     = in_acc && in_range && !i_kind;

    assign rd_pending = !r_rd_drained && (r_rd_total != '0);
    assign lvl_active = r_ind_rd[0] && rd_pending;
    assign chunk      = (r_rd_total > DATA_W'(CHUNK_BYTES)) ? CHUNK_BYTES : r_rd_total[8:0];
    assign lvl_sum    = {1'b0, chunk} + 10'd3;
    assign level_word = DATA_W'(lvl_sum[9:2]);

    always_comb begin
        ind_rd_view = r_ind_rd;
        if (r_ind_rd[0]) begin
            ind_rd_view[2] = rd_pending;
            ind_rd_view[5] = !rd_pending;
        end
        ind_wr_view = r_ind_wr;
        if (r_ind_wr[0]) begin
            ind_wr_view[2] = 1'b0;
            ind_wr_view[5] = 1'b1;
        end
    end

    always_comb begin
        n_irq_status = r_irq_status;
        n_irq_mask   = r_irq_mask;
        n_ind_rd     = r_ind_rd;
        n_rd_bytes   = r_rd_bytes;
        n_ind_wr     = r_ind_wr;
        n_cmd_ctrl   = r_cmd_ctrl;
        n_cmd_wr_lo  = r_cmd_wr_lo;
        n_rd_total   = r_rd_total;
        n_rd_drained = r_rd_drained;
        cmd_req      = '0;
        rd_special   = '0;
        use_mem      = 1'b0;
        sel_cfg      = 1'b0;
        sel_lvl      = 1'b0;
        if (in_acc && in_range) begin
            case (i_reg_index)
                W_CONFIG: begin
                    if (!i_kind) begin
                        use_mem = 1'b1;
                        sel_cfg = 1'b1;
                    end
                end
                W_SRAM_LEVEL: begin
                    if (!i_kind) begin
                        if (lvl_active) begin
                            rd_special = level_word;
                        end else begin
                            use_mem = 1'b1;
                            sel_lvl = 1'b1;
                        end
                    end
                end
                W_IRQ_STATUS: begin
                    if (i_kind) begin
                        n_irq_status = r_irq_status & ~i_write_data;
                    end else begin
                        rd_special = r_irq_status;
                    end
                end
                W_IRQ_MASK: begin
                    if (i_kind) begin
                        n_irq_mask = i_write_data;
                    end else begin
                        rd_special = r_irq_mask;
                    end
                end
                W_IND_RD_BYTES: begin
                    if (i_kind) begin
                        n_rd_bytes = i_write_data;
                    end else begin
                        rd_special = r_rd_bytes;
                    end
                end
                W_CMD_WR_LO: begin
                    if (i_kind) begin
                        n_cmd_wr_lo = i_write_data;
                    end else begin
                        rd_special = r_cmd_wr_lo;
                    end
                end
                W_IND_RD: begin
                    if (i_kind) begin
                        if (i_write_data[5]) begin
                            n_ind_rd     = '0;
                            n_rd_drained = 1'b1;
                        end else begin
                            n_ind_rd = i_write_data;
                            if (i_write_data[0]) begin
                                n_rd_total   = r_rd_bytes;
                                n_rd_drained = 1'b0;
                                n_irq_status = r_irq_status | 32'h0000_0044;
                            end
                            if (i_write_data[1]) begin
                                n_rd_drained  = 1'b1;
                                n_ind_rd[1:0] = 2'b00;
                            end
                        end
                    end else begin
                        rd_special = ind_rd_view;
                    end
                end
                W_IND_WR: begin
                    if (i_kind) begin
                        if (i_write_data[5]) begin
                            n_ind_wr = '0;
                        end else begin
                            n_ind_wr = i_write_data;
                            if (i_write_data[0]) begin
                                n_ind_wr[5]  = 1'b1;
                                n_ind_wr[2]  = 1'b0;
                                n_irq_status = r_irq_status | 32'h0000_0004;
                            end
                            if (i_write_data[1]) begin
                                n_ind_wr[1:0] = 2'b00;
                            end
                        end
                    end else begin
                        rd_special = ind_wr_view;
                    end
                end
                W_CMD_CTRL: begin
                    if (i_kind) begin
                        n_cmd_ctrl = i_write_data;
                        if (i_write_data[0]) begin
                            n_cmd_ctrl[1] = 1'b0;
                        end
                        cmd_req.go        = i_write_data[0];
                        cmd_req.op        = i_write_data[31:24];
                        cmd_req.wr_en     = i_write_data[15];
                        cmd_req.wr_cnt_nz = |i_write_data[14:12];
                        cmd_req.wr_data   = r_cmd_wr_lo[15:0];
                    end else begin
                        rd_special = r_cmd_ctrl;
                    end
                end
                W_CMD_RD_LO: begin
                    if (!i_kind) begin
                        rd_special = DATA_W'(cmd_buf);
                    end
                end
                W_CMD_RD_HI: begin
                    rd_special = '0;
                end
                default: begin
                    if (!i_kind) begin
                        use_mem = 1'b1;
                    end
                end
            endcase
        end
    end

    assign n_irq_level = |(n_irq_status & n_irq_mask);

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (mem_we) begin
            r_mem[addr] <= i_write_data;
        end
        if (mem_re) begin
            r_mem_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_irq_status <= '0;
            r_irq_mask   <= '0;
            r_ind_rd     <= '0;
            r_rd_bytes   <= '0;
            r_ind_wr     <= '0;
            r_cmd_ctrl   <= '0;
            r_cmd_wr_lo  <= '0;
            r_rd_total   <= '0;
            r_rd_drained <= 1'b1;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(NUM_WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_irq_status <= n_irq_status;
            r_irq_mask   <= n_irq_mask;
            r_ind_rd     <= n_ind_rd;
            r_rd_bytes   <= n_rd_bytes;
            r_ind_wr     <= n_ind_wr;
            r_cmd_ctrl   <= n_cmd_ctrl;
            r_cmd_wr_lo  <= n_cmd_wr_lo;
            r_rd_total   <= n_rd_total;
            r_rd_drained <= n_rd_drained;
            if (o_in_ready) begin
                r_s1_valid <= in_acc;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_use_mem <= use_mem;
            r_s1_cfg     <= sel_cfg;
            r_s1_lvl     <= sel_lvl;
            r_s1_data    <= rd_special;
            r_s1_irq     <= n_irq_level;
        end
        if (s1_adv) begin
            r_out_data <= s1_result;
            r_out_irq  <= r_s1_irq;
        end
    end

    assign s1_result = r_s1_use_mem
        ? ((r_mem_rdata & (r_s1_lvl ? LEVEL_RD_MASK : '1)) | (r_s1_cfg ? IDLE_BIT : '0))
        : r_s1_data;

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_irq_level = r_out_irq;

    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_acc)
        else $error("beat accepted during register file clear");

    a_irq_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind && i_reg_index == W_IRQ_STATUS && i_write_data == '1)
        |=> (r_irq_status == '0))
        else $error("irq status not cleared by all-ones write");

    a_ind_rd_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind && i_reg_index == W_IND_RD && i_write_data[5])
        |=> (r_rd_drained && r_ind_rd == '0))
        else $error("indirect read abort left transfer pending");

endmodule

// ===== tb/sv/qspi_controller_register_model_tb.sv =====
// Testbench for the QSPI controller register model: directed and random register traffic.
`timescale 1ns / 1ps

module qspi_controller_register_model_tb;

    import qcrm_pkg::*;

    localparam int NUM_WORDS  = NUM_WORDS_DEF;
    localparam int IDLE_LIMIT = 1000;

    localparam logic KIND_RD = 1'b0;
    localparam logic KIND_WR = 1'b1;

    localparam logic [31:0] CTL_START  = 32'h0000_0001;
    localparam logic [31:0] CTL_CANCEL = 32'h0000_0002;
    localparam logic [31:0] CTL_BUSY   = 32'h0000_0004;
    localparam logic [31:0] CTL_DONE   = 32'h0000_0020;
    localparam logic [31:0] IRQ_XFER   = 32'h0000_0004;
    localparam logic [31:0] IRQ_LEVEL  = 32'h0000_0040;
    localparam logic [31:0] CMD_GO     = 32'h0000_0001;
    localparam logic [31:0] CMD_BUSY   = 32'h0000_0002;

    typedef struct packed {
        logic        kind;
        logic [13:0] idx;
        logic [31:0] rd;
        logic        irq;
    } t_access_result;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                i_kind       = 1'b0;
    logic [IDX_W-1:0]    i_reg_index  = '0;
    logic [DATA_W-1:0]   i_write_data = '0;
    logic                i_out_ready  = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [DATA_W-1:0]   o_read_data;
    logic                o_irq_level;

    logic [31:0] shadow_regs [0:(1 << IDX_W) - 1];
    logic [63:0] cmd_rd_buf;
    logic [7:0]  flash_sr;
    logic [7:0]  flash_cr;
    logic [31:0] xfer_total;
    logic [31:0] xfer_drained;

    t_access_result pending_results [$];
    int             beats_sent  = 0;
    int             mismatches  = 0;
    int             idle_cycles = 0;
    bit             calm        = 1'b0;

    qspi_controller_register_model #(.NUM_WORDS(NUM_WORDS)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_irq_level  (o_irq_level)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit chance(int num, int den);
        return $urandom_range(0, den - 1) < num;
    endfunction

    function automatic t_access_result apply_access(logic kind, logic [13:0] idx,
                                                    logic [31:0] wd);
        t_access_result res;
        logic [31:0]    v;
        logic [31:0]    rem;
        logic [31:0]    chunk;
        logic [7:0]     op;
        res      = '0;
        res.kind = kind;
        res.idx  = idx;
        if (idx < NUM_WORDS) begin
            if (kind == KIND_WR) begin
                case (idx)
                    W_CMD_CTRL: begin
                        shadow_regs[W_CMD_CTRL] = wd;
                        if ((wd & CMD_GO) != 0) begin
                            op         = wd[31:24];
                            cmd_rd_buf = '0;
                            case (op)
                                OP_READ_ID:   cmd_rd_buf = {40'd0, ID_BYTES};
                                OP_RD_STATUS: cmd_rd_buf = {56'd0, flash_sr};
                                OP_RD_CONFIG: cmd_rd_buf = {56'd0, flash_cr};
                                OP_WREN:      flash_sr = flash_sr | WEL_MASK;
                                OP_WRDI:      flash_sr = flash_sr & ~WEL_MASK;
                                OP_WRSR: begin
                                    if (wd[15] && (flash_sr & WEL_MASK) != 0) begin
                                        v        = shadow_regs[W_CMD_WR_LO];
                                        flash_sr = v[7:0] & ~WEL_MASK;
                                        if (wd[14:12] != 3'd0)
                                            flash_cr = v[15:8];
                                    end
                                    flash_sr = flash_sr & ~WEL_MASK;
                                end
                                default: ;
                            endcase
                            shadow_regs[W_CMD_CTRL] = wd & ~CMD_BUSY;
                        end
                    end
                    W_IND_RD: begin
                        if ((wd & CTL_DONE) != 0) begin
                            shadow_regs[W_IND_RD] = '0;
                            xfer_drained          = xfer_total;
                        end else begin
                            shadow_regs[W_IND_RD] = wd;
                            if ((wd & CTL_START) != 0) begin
                                xfer_total                = shadow_regs[W_IND_RD_BYTES];
                                xfer_drained              = '0;
                                shadow_regs[W_IRQ_STATUS] |= IRQ_LEVEL | IRQ_XFER;
                            end
                            if ((wd & CTL_CANCEL) != 0) begin
                                xfer_drained          = xfer_total;
                                shadow_regs[W_IND_RD] &= ~(CTL_START | CTL_CANCEL);
                            end
                        end
                    end
                    W_IND_WR: begin
                        if ((wd & CTL_DONE) != 0) begin
                            shadow_regs[W_IND_WR] = '0;
                        end else begin
                            shadow_regs[W_IND_WR] = wd;
                            if ((wd & CTL_START) != 0) begin
                                shadow_regs[W_IND_WR]     = (wd | CTL_DONE) & ~CTL_BUSY;
                                shadow_regs[W_IRQ_STATUS] |= IRQ_XFER;
                            end
                            if ((wd & CTL_CANCEL) != 0)
                                shadow_regs[W_IND_WR] &= ~(CTL_START | CTL_CANCEL);
                        end
                    end
                    W_IRQ_STATUS: shadow_regs[W_IRQ_STATUS] &= ~wd;
                    default:      shadow_regs[idx] = wd;
                endcase
            end else begin
                case (idx)
                    W_CONFIG: res.rd = shadow_regs[W_CONFIG] | IDLE_BIT;
                    W_SRAM_LEVEL: begin
                        if ((shadow_regs[W_IND_RD] & CTL_START) != 0
                                && xfer_drained < xfer_total) begin
                            rem    = xfer_total - xfer_drained;
                            chunk  = (rem < CHUNK_BYTES) ? rem : 32'(CHUNK_BYTES);
                            res.rd = ((chunk + 32'd3) / 32'd4) & LEVEL_RD_MASK;
                        end else begin
                            res.rd = shadow_regs[W_SRAM_LEVEL] & LEVEL_RD_MASK;
                        end
                    end
                    W_CMD_RD_LO: res.rd = cmd_rd_buf[31:0];
                    W_CMD_RD_HI: res.rd = cmd_rd_buf[63:32];
                    W_IND_RD: begin
                        v = shadow_regs[W_IND_RD];
                        if ((v & CTL_START) != 0) begin
                            if (xfer_drained < xfer_total)
                                v = (v | CTL_BUSY) & ~CTL_DONE;
                            else
                                v = (v & ~CTL_BUSY) | CTL_DONE;
                        end
                        res.rd = v;
                    end
                    W_IND_WR: begin
                        v = shadow_regs[W_IND_WR];
                        if ((v & CTL_START) != 0)
                            v = (v & ~CTL_BUSY) | CTL_DONE;
                        res.rd = v;
                    end
                    default: res.rd = shadow_regs[idx];
                endcase
            end
        end
        res.irq = (shadow_regs[W_IRQ_STATUS] & shadow_regs[W_IRQ_MASK]) != 0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("ERROR %s: got %h, expected %h", what, got, want);
    endtask

    task automatic send_beat(input logic kind, input logic [13:0] idx, input logic [31:0] wd);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_reg_index  <= idx;
        i_write_data <= wd;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        pending_results.push_back(apply_access(kind, idx, wd));
        beats_sent++;
    endtask

    // result side: random stalls, compare each beat with the oldest prediction
    initial begin
        int             stall;
        t_access_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", o_read_data, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.rd)
                    report_mismatch($sformatf("read_data kind %0d idx %0d", want.kind,
                                              want.idx), o_read_data, want.rd);
                if (o_irq_level !== want.irq)
                    report_mismatch($sformatf("irq_level kind %0d idx %0d", want.kind,
                                              want.idx), 32'(o_irq_level), 32'(want.irq));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1)
                || (o_out_valid === 1'b1 && i_out_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic test_register_range;
        send_beat(KIND_RD, W_CONFIG, 32'h0);
        send_beat(KIND_WR, W_CONFIG, 32'h0);
        send_beat(KIND_RD, W_CONFIG, 32'hFFFF_FFFF);
        send_beat(KIND_WR, 14'(NUM_WORDS - 1), 32'hFFFF_FFFF);
        send_beat(KIND_RD, 14'(NUM_WORDS - 1), 32'h0);
        send_beat(KIND_WR, 14'h3FFF, 32'hFFFF_FFFF);
        send_beat(KIND_RD, 14'h3FFF, 32'h0);
        send_beat(KIND_RD, 14'(NUM_WORDS), 32'h0);
    endtask

    task automatic test_flash_commands;
        send_beat(KIND_WR, W_CMD_CTRL, {OP_READ_ID, 24'h000001});
        send_beat(KIND_RD, W_CMD_RD_LO, 32'h0);
        send_beat(KIND_WR, W_CMD_WR_LO, 32'h0000_A5FF);
        send_beat(KIND_WR, W_CMD_CTRL, {OP_WREN, 24'h000001});
        send_beat(KIND_WR, W_CMD_CTRL, {OP_WRSR, 24'h00F003});
        send_beat(KIND_WR, W_CMD_CTRL, {OP_RD_STATUS, 24'h000001});
        send_beat(KIND_RD, W_CMD_RD_LO, 32'h0);
        send_beat(KIND_WR, W_CMD_CTRL, {OP_RD_CONFIG, 24'h000001});
        send_beat(KIND_RD, W_CMD_RD_LO, 32'h0);
        send_beat(KIND_WR, W_CMD_CTRL, {OP_WRDI, 24'h000003});
        send_beat(KIND_RD, W_CMD_CTRL, 32'h0);
    endtask

    task automatic test_indirect_transfers;
        send_beat(KIND_WR, W_IRQ_MASK, 32'hFFFF_FFFF);
        send_beat(KIND_WR, W_IND_RD_BYTES, 32'd300);
        send_beat(KIND_WR, W_IND_RD, CTL_START);
        send_beat(KIND_RD, W_SRAM_LEVEL, 32'h0);
        send_beat(KIND_RD, W_IND_RD, 32'h0);
        send_beat(KIND_WR, W_IND_RD, CTL_CANCEL);
        send_beat(KIND_WR, W_IND_WR, CTL_START);
        send_beat(KIND_RD, W_IND_WR, 32'h0);
        send_beat(KIND_WR, W_IRQ_STATUS, 32'hFFFF_FFFF);
        send_beat(KIND_RD, W_IRQ_STATUS, 32'h0);
    endtask

    task automatic test_random_traffic(int n_items);
        int          stop_at;
        int          pick;
        logic [31:0] d;
        logic [31:0] total;
        logic [7:0]  op;
        logic [13:0] idx;
        stop_at = beats_sent + n_items;
        while (beats_sent < stop_at) begin
            calm = chance(1, 4);
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                case ($urandom_range(0, 7))
                    0:       op = OP_READ_ID;
                    1:       op = OP_RD_STATUS;
                    2:       op = OP_RD_CONFIG;
                    3:       op = OP_WREN;
                    4:       op = OP_WRDI;
                    5, 6:    op = OP_WRSR;
                    default: op = 8'($urandom_range(0, 255));
                endcase
                if (chance(2, 3))
                    send_beat(KIND_WR, W_CMD_CTRL, {OP_WREN, 24'h000001});
                if (chance(3, 4))
                    send_beat(KIND_WR, W_CMD_WR_LO, $urandom());
                d        = $urandom();
                d[31:24] = op;
                d[0]     = chance(9, 10);
                d[15]    = chance(3, 4);
                if (chance(1, 3))
                    d[14:12] = 3'd0;
                send_beat(KIND_WR, W_CMD_CTRL, d);
                send_beat(KIND_RD, W_CMD_CTRL, $urandom());
                send_beat(KIND_RD, W_CMD_RD_LO, $urandom());
                send_beat(KIND_RD, W_CMD_RD_HI, $urandom());
                if (op == OP_WRSR) begin
                    send_beat(KIND_WR, W_CMD_CTRL, {OP_RD_STATUS, 23'(chance(1, 2)), 1'b1});
                    send_beat(KIND_RD, W_CMD_RD_LO, $urandom());
                    send_beat(KIND_WR, W_CMD_CTRL, {OP_RD_CONFIG, 23'($urandom()), 1'b1});
                    send_beat(KIND_RD, W_CMD_RD_LO, $urandom());
                end
            end else if (pick < 47) begin
                case ($urandom_range(0, 4))
                    0:       total = 32'd0;
                    1:       total = $urandom_range(1, 256);
                    2:       total = $urandom_range(257, 4096);
                    3:       total = $urandom();
                    default: total = $urandom_range(1, 8);
                endcase
                send_beat(KIND_WR, W_IND_RD_BYTES, total);
                if (chance(1, 3))
                    send_beat(KIND_WR, W_IRQ_MASK, chance(1, 2) ? 32'hFFFF_FFFF : $urandom());
                d    = $urandom();
                d[0] = chance(9, 10);
                d[1] = chance(1, 5);
                d[5] = chance(1, 8);
                send_beat(KIND_WR, W_IND_RD, d);
                if (chance(1, 4))
                    send_beat(KIND_WR, W_SRAM_LEVEL, $urandom());
                send_beat(KIND_RD, W_SRAM_LEVEL, $urandom());
                send_beat(KIND_RD, W_IND_RD, $urandom());
                send_beat(KIND_RD, W_IRQ_STATUS, $urandom());
                if (chance(1, 2)) begin
                    case ($urandom_range(0, 2))
                        0:       d = CTL_CANCEL;
                        1:       d = CTL_DONE;
                        default: d = $urandom();
                    endcase
                    send_beat(KIND_WR, W_IND_RD, d);
                    send_beat(KIND_RD, W_IND_RD, $urandom());
                    send_beat(KIND_RD, W_SRAM_LEVEL, $urandom());
                end
            end else if (pick < 62) begin
                d    = $urandom();
                d[0] = chance(4, 5);
                d[1] = chance(1, 5);
                d[5] = chance(1, 8);
                send_beat(KIND_WR, W_IND_WR, d);
                send_beat(KIND_RD, W_IND_WR, $urandom());
                send_beat(KIND_RD, W_IRQ_STATUS, $urandom());
                if (chance(1, 2)) begin
                    send_beat(KIND_WR, W_IND_WR, chance(1, 2) ? CTL_CANCEL : CTL_DONE);
                    send_beat(KIND_RD, W_IND_WR, $urandom());
                end
            end else if (pick < 74) begin
                send_beat(KIND_WR, W_IRQ_MASK, $urandom());
                send_beat(KIND_WR, W_IRQ_STATUS, chance(1, 3) ? 32'hFFFF_FFFF : $urandom());
                send_beat(KIND_RD, W_IRQ_STATUS, $urandom());
                send_beat(KIND_RD, W_IRQ_MASK, $urandom());
            end else if (pick < 88) begin
                idx = 14'($urandom_range(0, NUM_WORDS - 1));
                send_beat(KIND_WR, idx, $urandom());
                send_beat(chance(1, 2) ? KIND_RD : KIND_WR, 14'($urandom_range(0, NUM_WORDS - 1)),
                          $urandom());
                send_beat(KIND_RD, idx, $urandom());
            end else begin
                idx = 14'($urandom_range(NUM_WORDS, 16383));
                send_beat(chance(1, 2) ? KIND_RD : KIND_WR, idx, $urandom());
                send_beat(KIND_RD, idx, $urandom());
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        shadow_regs[W_CONFIG] = IDLE_BIT;
        cmd_rd_buf            = '0;
        flash_sr              = '0;
        flash_cr              = '0;
        xfer_total            = '0;
        xfer_drained          = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_range();
        test_flash_commands();
        test_indirect_transfers();
        test_random_traffic(1700);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
